// ===== hw/rtl/lphi_pkg.sv =====
package lphi_pkg;

    // table geometry
    localparam int TABLE_SIZE     = 1024;
    localparam int MAX_KEY_LENGTH = 64;
    localparam int BYTE_OFFSET    = 65;

    localparam int ADDR_W = $clog2(TABLE_SIZE);
    localparam int SIZE_W = $clog2(TABLE_SIZE + 1);
    localparam int LEN_W  = $clog2(MAX_KEY_LENGTH + 2);
    localparam int SUM_W  = $clog2(MAX_KEY_LENGTH * (255 + BYTE_OFFSET) + 1);
    localparam int HANDLE_W  = 16;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    // result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_READ,
        S_CHECK
    } t_state;

    // request to the remainder unit
    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [SIZE_W-1:0] divisor;
    } t_mod_req;

    // access to the slot store
    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic                wocc;
        logic [HANDLE_W-1:0] whandle;
        logic [ADDR_W-1:0]   raddr;
    } t_slot_req;

endpackage

// ===== hw/rtl/lphi_mod_unit.sv =====
module lphi_mod_unit
    import lphi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mod_req          i_req,
    output logic              o_done,
    output logic [SIZE_W-1:0] o_rem
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0]     r_dvd, n_dvd;
    logic [SIZE_W-1:0]    r_dvs, n_dvs;
    logic [SIZE_W-1:0]    r_rem, n_rem;
    logic [SIZE_W:0]      w_trial;

    // one quotient bit per cycle, only the remainder is kept
    assign w_trial = {r_rem, r_dvd[SUM_W-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(SUM_W - 1);
            n_dvd  = i_req.dividend;
            n_dvs  = i_req.divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[SUM_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_dvs}) begin
                n_rem = SIZE_W'(w_trial - {1'b0, r_dvs});
            end else begin
                n_rem = w_trial[SIZE_W-1:0];
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hw/rtl/lphi_slot_store.sv =====
module lphi_slot_store
    import lphi_pkg::*;
(
    input  logic      i_clk,
    input  t_slot_req i_req,
    output logic      o_rd_occ
);

    logic                r_occ [TABLE_SIZE];
    logic [HANDLE_W-1:0] r_handle [TABLE_SIZE];
    logic                r_rd_occ;

    // occupancy flags, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_occ[i_req.waddr] <= i_req.wocc;
        end
        r_rd_occ <= r_occ[i_req.raddr];
    end

    // handle store, filled on insert
    always_ff @(posedge i_clk) begin
        if (i_req.we && i_req.wocc) begin
            r_handle[i_req.waddr] <= i_req.whandle;
        end
    end

    assign o_rd_occ = r_rd_occ;

endmodule

// ===== hw/rtl/linear_probe_hash_insert_core.sv =====
// Hash insert with linear probing. Key bytes enter on start while busy is low, one per
// cycle; the byte with i_key_last set triggers the insert and raises busy until the
// result is out. The result appears on o_valid for exactly one cycle and cannot be
// held off. An insert is launched, runs through the bit-serial remainder unit, then
// makes one read of the occupancy memory and one check per probed slot. A key
// that is too long gives its result the cycle after its last byte without raising busy.
// After reset the block clears the occupancy memory with busy high; configuration
// writes are taken during that time.
module linear_probe_hash_insert_core
    import lphi_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [7:0]          i_key_byte,
    input  logic                i_key_last,
    input  logic [15:0]         i_key_handle,
    input  logic                i_cfg_we,
    input  logic [10:0]         i_cfg_wdata,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic [9:0]          o_bucket,
    output logic [10:0]         o_collisions,
    output logic [10:0]         o_max_collisions_seen
);

    t_state              r_state, n_state;
    logic [SIZE_W-1:0]   r_size;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [SIZE_W-1:0]   r_max, n_max;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0]   r_pos, n_pos;
    logic [SIZE_W-1:0]   r_probes, n_probes;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_status, n_status;
    logic [ADDR_W-1:0]   r_bucket, n_bucket;
    logic [SIZE_W-1:0]   r_coll, n_coll;

    logic [SIZE_W-1:0]   w_n;
    logic                w_len_full;
    logic [SUM_W-1:0]    w_acc_sum;
    logic                w_accept;
    logic                w_launch;
    logic [SIZE_W-1:0]   w_pos_inc;
    logic [SIZE_W-1:0]   w_probes_inc;
    logic                w_mod_done;
    logic [SIZE_W-1:0]   w_rem;
    logic                w_rd_occ;
    t_mod_req            w_mod_req;
    t_slot_req           w_slot_req;

    // table size in use, clamped to a legal range
    always_comb begin
        if (r_size == '0) begin
            w_n = SIZE_W'(1);
        end else if (r_size > SIZE_W'(TABLE_SIZE)) begin
            w_n = SIZE_W'(TABLE_SIZE);
        end else begin
            w_n = r_size;
        end
    end

    assign w_accept     = start && !busy;
    assign w_len_full   = (r_len >= LEN_W'(MAX_KEY_LENGTH));
    assign w_acc_sum    = r_sum + SUM_W'(i_key_byte) + SUM_W'(BYTE_OFFSET);
    assign w_launch     = w_accept && i_key_last && !w_len_full;
    assign w_pos_inc    = SIZE_W'(r_pos) + 1'b1;
    assign w_probes_inc = r_probes + 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_W'(TABLE_SIZE);
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(TABLE_SIZE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_launch) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_mod_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!w_rd_occ || (w_probes_inc == w_n)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_READ;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // outputs towards the remainder unit and the slot store
    always_comb begin
        busy                = (r_state != S_IDLE);
        w_mod_req.start     = w_launch;
        w_mod_req.dividend  = w_acc_sum;
        w_mod_req.divisor   = w_n;
        w_slot_req.we       = 1'b0;
        w_slot_req.waddr    = r_pos;
        w_slot_req.wocc     = 1'b0;
        w_slot_req.whandle  = r_handle;
        w_slot_req.raddr    = r_pos;
        case (r_state)
            S_CLEAR: begin
                w_slot_req.we    = 1'b1;
                w_slot_req.waddr = r_clr_addr;
            end
            S_CHECK: begin
                if (!w_rd_occ) begin
                    w_slot_req.we   = 1'b1;
                    w_slot_req.wocc = 1'b1;
                end
            end
            default: begin
                w_slot_req.we = 1'b0;
            end
        endcase
    end

    // datapath: key accumulation, probe walk and result
    always_comb begin
        n_sum       = r_sum;
        n_len       = r_len;
        n_max       = r_max;
        n_clr_addr  = r_clr_addr;
        n_pos       = r_pos;
        n_probes    = r_probes;
        n_handle    = r_handle;
        n_out_valid = 1'b0;
        n_status    = r_status;
        n_bucket    = r_bucket;
        n_coll      = r_coll;
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (!w_len_full) begin
                        n_sum = w_acc_sum;
                        n_len = r_len + 1'b1;
                    end else begin
                        n_len = LEN_W'(MAX_KEY_LENGTH + 1);
                    end
                    if (i_key_last) begin
                        n_sum    = '0;
                        n_len    = '0;
                        n_handle = i_key_handle;
                        if (w_len_full) begin
                            n_out_valid = 1'b1;
                            n_status    = ST_TOO_LONG;
                            n_bucket    = '0;
                            n_coll      = '0;
                        end
                    end
                end
            end
            S_DIV: begin
                if (w_mod_done) begin
                    n_pos    = w_rem[ADDR_W-1:0];
                    n_probes = '0;
                end
            end
            S_CHECK: begin
                if (!w_rd_occ) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_INSERTED;
                    n_bucket    = r_pos;
                    n_coll      = r_probes;
                    if (r_probes > r_max) begin
                        n_max = r_probes;
                    end
                end else if (w_probes_inc == w_n) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_FULL;
                    n_bucket    = '0;
                    n_coll      = '0;
                    if (w_probes_inc > r_max) begin
                        n_max = w_probes_inc;
                    end
                end else begin
                    n_probes = w_probes_inc;
                    n_pos    = (w_pos_inc >= w_n) ? '0 : w_pos_inc[ADDR_W-1:0];
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sum       <= '0;
            r_len       <= '0;
            r_max       <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_len       <= n_len;
            r_max       <= n_max;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
        r_pos    <= n_pos;
        r_probes <= n_probes;
        r_handle <= n_handle;
        r_status <= n_status;
        r_bucket <= n_bucket;
        r_coll   <= n_coll;
    end

    // remainder unit for the home bucket
    lphi_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mod_req),
        .o_done  (w_mod_done),
        .o_rem   (w_rem)
    );

    // occupancy and handle memories
    lphi_slot_store u_store (
        .i_clk    (i_clk),
        .i_req    (w_slot_req),
        .o_rd_occ (w_rd_occ)
    );

    assign o_valid               = r_out_valid;
    assign o_status              = r_status;
    assign o_bucket              = r_bucket;
    assign o_collisions          = r_coll;
    assign o_max_collisions_seen = r_max;

    // occupancy data is only checked the cycle after its read
    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> ($past(r_state) == S_READ))
        else $error("probe check without a preceding read");

    // the remainder unit only finishes while the controller waits for it
    a_mod_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == S_DIV))
        else $error("remainder finished outside the divide wait");

    // the running maximum never trails a reported collision count
    a_max_covers_coll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_collisions <= o_max_collisions_seen))
        else $error("collision count above running maximum");

    // no result leaves an unsuccessful item with a bucket or collisions
    a_fail_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_INSERTED)) |-> ((o_bucket == '0) && (o_collisions == '0)))
        else $error("failed item carries bucket or collisions");

    // the probe walk never leaves the table in use
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (SIZE_W'(r_pos) < w_n))
        else $error("probe position beyond table size in use");

endmodule
